// ----- src/hjs_pkg.sv -----
package hjs_pkg;

  localparam int MAX_WORKERS = 256;
  localparam int TIME_BITS   = 48;
  localparam int DUR_BITS    = 32;
  localparam int WORKER_BITS = $clog2(MAX_WORKERS);
  localparam int CNT_BITS    = WORKER_BITS + 1;
  localparam int KEY_BITS    = TIME_BITS + WORKER_BITS;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // finish time in the upper bits so a plain compare is lexicographic
  typedef struct packed {
    logic [TIME_BITS-1:0]   finish;
    logic [WORKER_BITS-1:0] worker;
  } key_t;

  typedef struct packed {
    logic                  clear;
    logic [CNT_BITS-1:0]   count;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DUR_BITS-1:0]   duration;
  } sift_req_t;

  typedef struct packed {
    logic busy;
    key_t root;
  } sift_stat_t;

  typedef struct packed {
    logic swap;
    logic take_right;
    key_t child;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } sift_state_e;

endpackage

// ----- src/hjs_ram.sv -----
module hjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- src/hjs_cmp_unit.sv -----
module hjs_cmp_unit (
  input  hjs_pkg::key_t     cur_i,
  input  hjs_pkg::key_t     left_i,
  input  hjs_pkg::key_t     right_i,
  input  logic              right_ok_i,
  output hjs_pkg::cmp_res_t res_o
);
  import hjs_pkg::*;

  logic lt_lx;
  logic lt_rx;
  logic lt_rl;

  // three compares side by side, then a small select
  assign lt_lx = left_i < cur_i;
  assign lt_rx = right_i < cur_i;
  assign lt_rl = right_i < left_i;

  always_comb begin
    res_o.take_right = right_ok_i && lt_rl;
    res_o.child      = res_o.take_right ? right_i : left_i;
    res_o.swap       = res_o.take_right ? lt_rx : lt_lx;
  end

endmodule

// ----- src/hjs_sifter.sv -----
module hjs_sifter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hjs_pkg::cfg_t      cfg_i,
  input  hjs_pkg::sift_req_t req_i,
  output hjs_pkg::sift_stat_t stat_o
);
  import hjs_pkg::*;

  sift_state_e            state_q, state_d;
  logic [WORKER_BITS-1:0] pos_q, pos_d;
  key_t                   x_q, x_d;
  key_t                   root_q;
  logic [MAX_WORKERS-1:0] valid_q;
  logic                   lvalid_q, rvalid_q, rok_q;
  logic                   lat_en;

  logic [CNT_BITS-1:0]    l_idx;
  logic [CNT_BITS:0]      r_idx;
  logic                   l_ok, r_ok;
  logic [TIME_BITS:0]     sum;
  key_t                   x_start;

  logic                   we;
  key_t                   wdata;
  key_t                   rd_l, rd_r;
  key_t                   left_key, right_key;
  cmp_res_t               cmp;

  assign l_idx = {pos_q, 1'b1};
  assign r_idx = {1'b0, pos_q, 1'b1} + (CNT_BITS + 1)'(1);
  assign l_ok  = l_idx < cfg_i.count;
  assign r_ok  = r_idx < {1'b0, cfg_i.count};

  // saturating finish update of the root
  assign sum = {1'b0, root_q.finish} + (TIME_BITS + 1)'(req_i.duration);
  always_comb begin
    x_start.worker = root_q.worker;
    x_start.finish = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  end

  hjs_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(MAX_WORKERS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (pos_q),
    .wdata_i   (wdata),
    .raddr_a_i (l_idx[WORKER_BITS-1:0]),
    .raddr_b_i (r_idx[WORKER_BITS-1:0]),
    .rdata_a_o (rd_l),
    .rdata_b_o (rd_r)
  );

  // never-written slots read as their reset contents
  always_comb begin
    left_key  = rd_l;
    right_key = rd_r;
    if (!lvalid_q) begin
      left_key.finish = '0;
      left_key.worker = l_idx[WORKER_BITS-1:0];
    end
    if (!rvalid_q) begin
      right_key.finish = '0;
      right_key.worker = r_idx[WORKER_BITS-1:0];
    end
  end

  hjs_cmp_unit u_cmp (
    .cur_i      (x_q),
    .left_i     (left_key),
    .right_i    (right_key),
    .right_ok_i (rok_q),
    .res_o      (cmp)
  );

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    x_d     = x_q;
    we      = 1'b0;
    wdata   = x_q;
    lat_en  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          x_d     = x_start;
          pos_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (l_ok) begin
          lat_en  = 1'b1;
          state_d = ST_CMP;
        end else begin
          we      = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CMP: begin
        we = 1'b1;
        if (cmp.swap) begin
          wdata   = cmp.child;
          pos_d   = cmp.take_right ? r_idx[WORKER_BITS-1:0] : l_idx[WORKER_BITS-1:0];
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      root_q  <= '0;
    end else if (cfg_i.clear) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      root_q  <= '0;
    end else begin
      state_q <= state_d;
      if (we) begin
        valid_q[pos_q] <= 1'b1;
        if (pos_q == '0) begin
          root_q <= wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    x_q   <= x_d;
    if (lat_en) begin
      lvalid_q <= valid_q[l_idx[WORKER_BITS-1:0]];
      rvalid_q <= valid_q[r_idx[WORKER_BITS-1:0]];
      rok_q    <= r_ok;
    end
  end

  assign stat_o.busy = state_q != ST_IDLE;
  assign stat_o.root = root_q;

endmodule

// ----- src/heap_job_scheduler_core.sv -----
// heap job scheduler: hands each job to the worker that is free earliest
//
// s_axis carries one job duration per transaction. for each one, m_axis
// returns the chosen worker and its free time, which is the job's start.
// cfg carries the worker count (1..256, 0 reads as 1, larger clamps to 256);
// a write resets every worker's finish time to zero. write it only while idle.
//
// the result is registered at the input transaction, so it shows on m_axis
// in the next cycle. the heap repair then runs as a sift-down on a shared
// compare unit, a dual-port ram read and then a compare and write back per
// heap level, ending with a write back of the sifted key. the next job is
// taken only once the sift-down has finished.
//
// reset: all workers idle with finish time zero, worker count one; no
// clearing pass, per-slot valid flops stand for the reset contents.
// a stalled m_axis holds its transaction; s_axis is not taken while a
// result would have nowhere to go.
module heap_job_scheduler_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hjs_pkg::CNT_BITS-1:0] cfg_data_i,   // worker_count
  // job input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // [31:0] job_duration
  // assignment output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata    // [7:0] worker_index, [55:8] start_time
);
  import hjs_pkg::*;

  logic [CNT_BITS-1:0] count_q;
  logic [CNT_BITS-1:0] count_d;
  logic                cfg_fire;
  logic                in_fire;
  logic                out_valid_q;
  key_t                out_q;
  cfg_t                cfg;
  sift_req_t           req;
  sift_stat_t          stat;

  // config is taken at any time
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  always_comb begin
    count_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      count_d = CNT_BITS'(1);
    end else if (cfg_data_i > CNT_BITS'(MAX_WORKERS)) begin
      count_d = CNT_BITS'(MAX_WORKERS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_BITS'(1);
    end else if (cfg_fire) begin
      count_q <= count_d;
    end
  end

  assign cfg.clear = cfg_fire;
  assign cfg.count = count_q;

  // accept only when the sift is done and the output slot frees up
  assign s_axis_tready = !stat.busy && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign req.start    = in_fire;
  assign req.duration = s_axis_tdata[DUR_BITS-1:0];

  hjs_sifter u_sifter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .stat_o (stat)
  );

  // output register: the root before this job's update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= stat.root;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.finish, out_q.worker};

endmodule

// ----- src/hjs_checker.sv -----
module hjs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // each accepted job yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after accepted job");

  // the heap repair keeps the input closed right after a job
  a_busy_after_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready during heap repair");

  // no job is taken while a result is stuck
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while output stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind heap_job_scheduler_core hjs_checker u_hjs_checker (.*);

// ----- dv/tb_top.sv -----
module tb_top;
  import hjs_pkg::*;

  // settle time after the last result: the sift-down keeps running after
  // the result shows, plus some margin
  localparam int SIFT_SETTLE = 24;

  // one result: worker handed the job and its start time
  typedef struct packed {
    logic [WORKER_BITS-1:0] worker;
    logic [TIME_BITS-1:0]   start;
  } assignment_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CNT_BITS-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;  // [31:0] job_duration
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [55:0]           m_axis_tdata;        // [7:0] worker_index, [55:8] start_time

  heap_job_scheduler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // scheduler prediction: own copy of the worker heap and worker count
  // ---------------------------------------------------------------------
  key_t        worker_heap [MAX_WORKERS];
  int unsigned active_workers;

  assignment_t expected_assignments [$];

  int error_count       = 0;
  int jobs_sent         = 0;
  int results_checked   = 0;
  int count_writes      = 0;
  int saturated_results = 0;

  // a count write puts every worker back at time zero, in index order
  function automatic void restart_workers(input logic [CNT_BITS-1:0] req);
    int unsigned n;
    n = req;
    if (n == 0) n = 1;                     // zero reads as one worker
    if (n > MAX_WORKERS) n = MAX_WORKERS;  // clamp at the heap size
    active_workers = n;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      worker_heap[i].finish = '0;
      worker_heap[i].worker = WORKER_BITS'(i);
    end
  endfunction

  // hand a job to the root worker, push its finish time out and sift down
  function automatic assignment_t assign_job(input logic [DUR_BITS-1:0] dur);
    assignment_t  res;
    logic [TIME_BITS:0] sum;
    int unsigned  pos;
    int unsigned  lft;
    int unsigned  rgt;
    int unsigned  best;
    key_t         tmp;
    res.worker = worker_heap[0].worker;
    res.start  = worker_heap[0].finish;
    sum = {1'b0, worker_heap[0].finish} + (TIME_BITS + 1)'(dur);
    // finish time saturates instead of wrapping
    worker_heap[0].finish = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    pos = 0;
    while (1'b1) begin
      lft  = 2 * pos + 1;
      rgt  = lft + 1;
      best = pos;
      // packed key compares finish first, then worker index
      if (lft < active_workers && worker_heap[lft] < worker_heap[best]) best = lft;
      if (rgt < active_workers && worker_heap[rgt] < worker_heap[best]) best = rgt;
      if (best == pos) break;
      tmp               = worker_heap[pos];
      worker_heap[pos]  = worker_heap[best];
      worker_heap[best] = tmp;
      pos = best;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // monitor: predict on each job transaction, check each result transaction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    assignment_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_assignments.push_back(assign_job(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_assignments.size() == 0) begin
          $display("%0t: unexpected result: worker %0d start %0d", $time,
                   m_axis_tdata[7:0], m_axis_tdata[55:8]);
          error_count++;
        end else begin
          want = expected_assignments.pop_front();
          results_checked++;
          if (want.start == TIME_MAX) saturated_results++;
          if (m_axis_tdata[7:0] !== want.worker) begin
            $display("%0t: worker_index mismatch: expected %0d, actual %0d", $time,
                     want.worker, m_axis_tdata[7:0]);
            error_count++;
          end
          if (m_axis_tdata[55:8] !== want.start) begin
            $display("%0t: start_time mismatch: expected %0d, actual %0d", $time,
                     want.start, m_axis_tdata[55:8]);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result side: stalls of random length, switchable off for clean stretches
  // ---------------------------------------------------------------------
  bit rx_stalls   = 1'b0;
  int stall_pct   = 20;
  int stall_max   = 4;
  int stall_left  = 0;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_stalls || $urandom_range(99, 0) >= stall_pct) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_left    <= $urandom_range(stall_max, 1) - 1;
      m_axis_tready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // job side: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int burst_max  = 1;
  int gap_max    = 0;

  task automatic send_job(input logic [DUR_BITS-1:0] dur);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(burst_max, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      // only drop valid when the gap really has a cycle in it
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) begin
          s_axis_tdata <= $urandom;  // noise while idle
          @(posedge clk_i);
        end
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dur;
    do @(posedge clk_i); while (!s_axis_tready);
    jobs_sent++;
  endtask

  // stop sending and wait for every outstanding result, then settle
  task automatic drain_results(input int settle);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_assignments.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // worker count write, only with the scheduler idle
  task automatic write_worker_count(input logic [CNT_BITS-1:0] value);
    drain_results(SIFT_SETTLE);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CNT_BITS'($urandom);
    restart_workers(value);
    count_writes++;
  endtask

  task automatic set_traffic(input int gmax, input int bmax, input bit stalls,
                             input int spct, input int smax);
    gap_max   = gmax;
    burst_max = bmax;
    rx_stalls = stalls;
    stall_pct = spct;
    stall_max = smax;
  endtask

  function automatic logic [DUR_BITS-1:0] pick_duration();
    logic [DUR_BITS-1:0] one_hot;
    one_hot = 32'h1 << $urandom_range(31, 0);
    case ($urandom_range(9, 0))
      0, 1, 2: return $urandom_range(15, 0);
      3:       return '0;
      4:       return '1;
      5:       return one_hot;
      6:       return ~one_hot;
      7, 8:    return $urandom_range(1000, 0);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // one worker out of reset: every job lands on worker 0 back to back
  task automatic test_reset_defaults();
    set_traffic(0, 1, 1'b0, 0, 1);
    send_job('0);
    send_job('1);
    send_job(32'h0000_0001);
    send_job(32'hAAAA_5555);
    send_job(32'h5555_AAAA);
  endtask

  // zero counts as one worker, anything past the heap size clamps to it
  task automatic test_count_clamping();
    write_worker_count('0);
    send_job(32'd9);
    send_job(32'd3);
    write_worker_count('1);
    send_job(32'd100);
    send_job(32'd1);
    write_worker_count(CNT_BITS'(MAX_WORKERS + 1));
    send_job('1);
  endtask

  // equal finish times beyond index 9 must still resolve by worker index
  task automatic test_tie_order();
    write_worker_count(CNT_BITS'(12));
    set_traffic(2, 4, 1'b1, 30, 3);
    repeat (12) send_job(32'd7);
    repeat (4) send_job(32'd3);
  endtask

  // random worker counts, durations and traffic, mostly in long phases
  task automatic test_random_mix();
    int phase_jobs;
    int target;
    logic [CNT_BITS-1:0] count;
    target = jobs_sent + 700;
    while (jobs_sent < target) begin
      case ($urandom_range(7, 0))
        0:       count = CNT_BITS'(1);
        1:       count = CNT_BITS'(2);
        2:       count = CNT_BITS'(3);
        3:       count = CNT_BITS'(MAX_WORKERS);
        4:       count = CNT_BITS'($urandom_range(16, 4));
        5:       count = CNT_BITS'($urandom_range(MAX_WORKERS, 1));
        6:       count = CNT_BITS'(MAX_WORKERS - 1);
        default: count = CNT_BITS'($urandom);
      endcase
      write_worker_count(count);
      case ($urandom_range(3, 0))
        0:       set_traffic(0, 1, 1'b0, 0, 1);      // no idling at all
        1:       set_traffic(3, 16, 1'b1, 20, 3);
        2:       set_traffic(12, 4, 1'b1, 50, 20);
        default: set_traffic($urandom_range(8, 0), $urandom_range(8, 1), 1'b1,
                             $urandom_range(60, 5), $urandom_range(10, 1));
      endcase
      // larger heaps need more jobs before the sift-down gets deep
      phase_jobs = $urandom_range(60, 20) + active_workers / 2;
      for (int i = 0; i < phase_jobs; i++) begin
        // hold off mid-phase until the pipe is empty
        if (i == phase_jobs / 2) drain_results(0);
        send_job(pick_duration());
      end
    end
  endtask

  // one worker fed the largest durations, finish times climb well past 32 bits
  task automatic test_large_durations();
    write_worker_count(CNT_BITS'(1));
    set_traffic(0, 1, 1'b0, 0, 1);
    repeat (24) send_job('1);
    set_traffic(2, 2, 1'b1, 30, 4);
    send_job('1);
    send_job('0);
    send_job(32'd5);
  endtask

  initial begin
    restart_workers(CNT_BITS'(1));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_count_clamping();
    test_tie_order();
    test_random_mix();
    test_large_durations();

    drain_results(SIFT_SETTLE);
    if (expected_assignments.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_assignments.size());
      error_count++;
    end
    $display("covered %0d jobs over %0d worker count writes, %0d results checked",
             jobs_sent, count_writes, results_checked);
    $display("ties, count clamping and full-range durations (%0d saturated starts) exercised",
             saturated_results);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
